FILE: design/mdf_pkg.sv
// Shared types, opcodes and header helpers for the MoldUDP64 packet framer.
package mdf_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

  // Input opcodes
  localparam logic [2:0] OP_OPEN    = 3'd0;
  localparam logic [2:0] OP_MSG     = 3'd1;
  localparam logic [2:0] OP_BYTE    = 3'd2;
  localparam logic [2:0] OP_FINAL   = 3'd3;
  localparam logic [2:0] OP_HBEAT   = 3'd4;
  localparam logic [2:0] OP_END     = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_SESSION_HIGH = 2'd0;
  localparam logic [1:0] REG_SESSION_LOW  = 2'd1;
  localparam logic [1:0] REG_FIRST_SEQ    = 2'd2;
  localparam logic [1:0] REG_CAPACITY     = 2'd3;

  localparam logic [15:0] COUNT_LIMIT = 16'd65534;
  localparam logic [15:0] END_COUNT   = 16'hFFFF;
  localparam logic [15:0] HDR_LEN     = 16'(HEADER_BYTES);

  // Kinds of work the back end expands into results
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_BYTE,
    CMD_PREFIX,
    CMD_HEADER
  } mdf_kind_e;

  // One queued command: off = write offset (byte, prefix), val = byte, length or count
  typedef struct packed {
    mdf_kind_e   kind;
    logic [15:0] off;
    logic [15:0] val;
    logic [63:0] seq;
    logic [15:0] plen;
  } mdf_cmd_t;

  // Byte idx of the big-endian header: session(10), sequence(8), count(2)
  function automatic logic [7:0] hdr_byte(input logic [15:0] sh, input logic [63:0] sl,
                                          input logic [63:0] seq, input logic [15:0] cnt,
                                          input logic [HDR_IDX_W-1:0] idx);
    logic [HEADER_BYTES*8-1:0] hv;
    int unsigned               pos;
    hv  = {sh, sl, seq, cnt};
    pos = (HEADER_BYTES - 1 - int'(idx)) * 8;
    return hv[pos +: 8];
  endfunction

endpackage

FILE: design/moldudp64_packet_framer.sv
// MoldUDP64 packet framer: config registers, front end, command queue and back end.
// Each item passes through the command queue and then the back end's output register.
// Throughput: one item per cycle while commands yield one result and the output is ready;
// a message start yields two results and finalize, heartbeat and end of session twenty,
// from the back end's single result register. The queue lets input run ahead of a header.
// Reset (async, active low) clears the queue and output, sets sequences to 1, length 20.
module moldudp64_packet_framer import mdf_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // message_length[15:0], data_byte[23:16]
  input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // write_offset[15:0], write_byte[23:16], accepted[24],
                                      // packet_length[40:25], zero fill[47:41]
  output logic [0:0]  m_axis_tuser,   // write_valid[0]
  output logic        m_axis_tlast
);

  logic [15:0] session_high_q;
  logic [63:0] session_low_q;
  logic [15:0] capacity_q;

  logic        q_full, q_empty, q_push, q_pop;
  mdf_cmd_t    push_cmd, head_cmd;

  logic        wv, acc;
  logic [15:0] woff, plen;
  logic [7:0]  wbyte;

  // configuration registers; first_sequence lives in the front end state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_high_q <= '0;
      session_low_q  <= '0;
      capacity_q     <= 16'd1472;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SESSION_HIGH: session_high_q <= cfg_wdata_i[15:0];
        REG_SESSION_LOW:  session_low_q  <= cfg_wdata_i;
        REG_CAPACITY:     capacity_q     <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  mdf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seq_we_i         (cfg_we_i && (cfg_idx_i == REG_FIRST_SEQ)),
    .seq_wdata_i      (cfg_wdata_i),
    .capacity_i       (capacity_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .opcode_i         (s_axis_tuser),
    .message_length_i (s_axis_tdata[15:0]),
    .data_byte_i      (s_axis_tdata[23:16]),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (push_cmd)
  );

  mdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  mdf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .session_high_i  (session_high_q),
    .session_low_i   (session_low_q),
    .q_empty_i       (q_empty),
    .q_head_i        (head_cmd),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .write_valid_o   (wv),
    .write_offset_o  (woff),
    .write_byte_o    (wbyte),
    .accepted_o      (acc),
    .packet_length_o (plen),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, plen, acc, wbyte, woff};
  assign m_axis_tuser = wv;

endmodule

FILE: design/mdf_front.sv
// Front end: takes input items, keeps packet state and classifies each item into a command.
module mdf_front import mdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // first_sequence write
  input  logic        seq_we_i,
  input  logic [63:0] seq_wdata_i,
  input  logic [15:0] capacity_i,
  // input item
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] message_length_i,
  input  logic [7:0]  data_byte_i,
  // command queue push side
  input  logic        q_full_i,
  output logic        q_push_o,
  output mdf_cmd_t    q_cmd_o
);

  logic [63:0] run_seq_q, run_seq_d;
  logic [63:0] pkt_seq_q, pkt_seq_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] count_q, count_d;
  logic [15:0] wptr_q, wptr_d;
  logic [15:0] remain_q, remain_d;
  logic        drop_q, drop_d;

  logic        accept;
  logic [17:0] need_sum;
  logic        fits;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept;

  // space test for a message start
  assign need_sum = {2'b00, plen_q} + {2'b00, message_length_i} + 18'd2;
  assign fits     = (need_sum <= {2'b00, capacity_i}) && (count_q < COUNT_LIMIT);

  // state update and classification
  always_comb begin
    run_seq_d = run_seq_q;
    pkt_seq_d = pkt_seq_q;
    plen_d    = plen_q;
    count_d   = count_q;
    wptr_d    = wptr_q;
    remain_d  = remain_q;
    drop_d    = drop_q;
    q_cmd_o   = '{kind: CMD_NOP, off: '0, val: '0, seq: '0, plen: '0};

    case (opcode_i)
      OP_OPEN: begin
        plen_d    = HDR_LEN;
        wptr_d    = HDR_LEN;
        remain_d  = '0;
        drop_d    = 1'b0;
        count_d   = '0;
        pkt_seq_d = run_seq_q;
      end
      OP_MSG: begin
        remain_d = message_length_i;
        if (fits) begin
          drop_d        = 1'b0;
          q_cmd_o.kind  = CMD_PREFIX;
          q_cmd_o.off   = plen_q;
          q_cmd_o.val   = message_length_i;
          wptr_d        = plen_q + 16'd2;
          plen_d        = need_sum[15:0];
          count_d       = count_q + 16'd1;
          run_seq_d     = run_seq_q + 64'd1;
        end else begin
          drop_d = 1'b1;
        end
      end
      OP_BYTE: begin
        if (remain_q != '0) begin
          remain_d = remain_q - 16'd1;
          if (!drop_q) begin
            q_cmd_o.kind = CMD_BYTE;
            q_cmd_o.off  = wptr_q;
            q_cmd_o.val  = {8'h00, data_byte_i};
            wptr_d       = wptr_q + 16'd1;
          end
        end
      end
      OP_FINAL: begin
        q_cmd_o = '{kind: CMD_HEADER, off: '0, val: count_q, seq: pkt_seq_q, plen: plen_q};
      end
      OP_HBEAT, OP_END: begin
        plen_d   = HDR_LEN;
        wptr_d   = HDR_LEN;
        remain_d = '0;
        drop_d   = 1'b0;
        q_cmd_o  = '{kind: CMD_HEADER, off: '0,
                     val: (opcode_i == OP_END) ? END_COUNT : 16'h0000,
                     seq: run_seq_q, plen: HDR_LEN};
      end
      default: begin
      end
    endcase
  end

  // state registers; a first_sequence write reloads both sequences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_seq_q <= 64'd1;
      pkt_seq_q <= 64'd1;
      plen_q    <= HDR_LEN;
      count_q   <= '0;
      wptr_q    <= HDR_LEN;
      remain_q  <= '0;
      drop_q    <= 1'b0;
    end else if (seq_we_i) begin
      run_seq_q <= seq_wdata_i;
      pkt_seq_q <= seq_wdata_i;
    end else if (accept) begin
      run_seq_q <= run_seq_d;
      pkt_seq_q <= pkt_seq_d;
      plen_q    <= plen_d;
      count_q   <= count_d;
      wptr_q    <= wptr_d;
      remain_q  <= remain_d;
      drop_q    <= drop_d;
    end
  end

endmodule

FILE: design/mdf_queue.sv
// Small command FIFO between the front end and the back end.
module mdf_queue import mdf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mdf_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output mdf_cmd_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mdf_cmd_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command queue underflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("command queue count out of range");

endmodule

FILE: design/mdf_back.sv
// Back end: expands queued commands into result transfers through an output register.
module mdf_back import mdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] session_high_i,
  input  logic [63:0] session_low_i,
  // queue pop side
  input  logic        q_empty_i,
  input  mdf_cmd_t    q_head_i,
  output logic        q_pop_o,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_valid_o,
  output logic [15:0] write_offset_o,
  output logic [7:0]  write_byte_o,
  output logic        accepted_o,
  output logic [15:0] packet_length_o,
  output logic        last_o
);

  logic [HDR_IDX_W-1:0] idx_q;
  logic                 vld_q;
  logic                 wv_q, acc_q, last_q;
  logic [15:0]          off_q, plen_q;
  logic [7:0]           byte_q;

  logic                 load;
  logic                 gen;
  logic                 r_wv, r_acc, r_last;
  logic [15:0]          r_off, r_plen;
  logic [7:0]           r_byte;

  assign load    = ~vld_q | out_ready_i;
  assign gen     = load & ~q_empty_i;
  assign q_pop_o = gen & r_last;

  // result for the current step of the head command
  always_comb begin
    r_wv   = 1'b0;
    r_off  = '0;
    r_byte = '0;
    r_acc  = 1'b0;
    r_plen = '0;
    r_last = 1'b1;
    case (q_head_i.kind)
      CMD_BYTE: begin
        r_wv   = 1'b1;
        r_off  = q_head_i.off;
        r_byte = q_head_i.val[7:0];
      end
      CMD_PREFIX: begin
        r_wv  = 1'b1;
        r_acc = 1'b1;
        if (idx_q == '0) begin
          r_off  = q_head_i.off;
          r_byte = q_head_i.val[15:8];
          r_last = 1'b0;
        end else begin
          r_off  = q_head_i.off + 16'd1;
          r_byte = q_head_i.val[7:0];
        end
      end
      CMD_HEADER: begin
        r_wv   = 1'b1;
        r_off  = 16'(idx_q);
        r_byte = hdr_byte(session_high_i, session_low_i, q_head_i.seq, q_head_i.val, idx_q);
        r_plen = q_head_i.plen;
        r_last = (idx_q == HDR_IDX_W'(HEADER_BYTES - 1));
      end
      default: begin
      end
    endcase
  end

  // step counter within a command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (gen) begin
        idx_q <= r_last ? '0 : idx_q + 1'b1;
      end
      if (load) begin
        vld_q <= ~q_empty_i;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (gen) begin
      wv_q   <= r_wv;
      off_q  <= r_off;
      byte_q <= r_byte;
      acc_q  <= r_acc;
      plen_q <= r_plen;
      last_q <= r_last;
    end
  end

  assign out_valid_o     = vld_q;
  assign write_valid_o   = wv_q;
  assign write_offset_o  = off_q;
  assign write_byte_o    = byte_q;
  assign accepted_o      = acc_q;
  assign packet_length_o = plen_q;
  assign last_o          = last_q;

  a_step_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0 && !q_empty_i) |-> (q_head_i.kind == CMD_PREFIX || q_head_i.kind == CMD_HEADER))
    else $error("step counter left running on a one-result command");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < HDR_IDX_W'(HEADER_BYTES))
    else $error("header step counter past the header");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> (vld_q && $stable(off_q) && $stable(last_q)))
    else $error("stalled result changed");

endmodule
